>>> src/assert_macros.svh
// Assertion macros for the circular ROI depth mean RTL.
// No dependencies; included by crdm_ctrl, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante in a cycle requires cons in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante in a cycle requires cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/crdm_pkg.sv
// Package for the circular ROI depth mean block: field widths, register
// indexes, reset values, controller states and controller/datapath structs.
`default_nettype none

package crdm_pkg;

    localparam int CFG_DIM_W  = 13;
    localparam int RADIUS_W   = 8;
    localparam int CNT_W      = 18;
    localparam int MEAN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_RADIUS  = 2'd2;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 8'd25;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_DIVIDE,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic s2_last;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

>>> src/circular_roi_depth_mean_top.sv
// Circular ROI depth mean: one pixel per cycle within a frame.
// After the last pixel of a frame the input stalls through two pipeline stages,
// DEPTH_BITS + 18 divide steps and the result.
// The result holds until taken; the next frame's pixels are accepted after that.
// Reset (rst_n, async, active low) restores 640x480, radius 25, clears state.
// Top level: joins crdm_ctrl and crdm_datapath; depends on crdm_pkg.
`default_nettype none

module circular_roi_depth_mean_top #(
    parameter int DEPTH_BITS    = 16,
    parameter int MAX_FRAME_DIM = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [crdm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [crdm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [DEPTH_BITS-1:0]            depth_sample,
    input  wire logic                             sample_valid,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [crdm_pkg::MEAN_W-1:0]           mean_depth,
    output logic [crdm_pkg::CNT_W-1:0]            valid_pixels,
    output logic                                  no_valid_pixels
);

    crdm_pkg::dp_cmd_t    cmd;
    crdm_pkg::dp_status_t status;

    crdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    crdm_datapath #(
        .DEPTH_BITS    (DEPTH_BITS),
        .MAX_FRAME_DIM (MAX_FRAME_DIM)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .depth_sample    (depth_sample),
        .sample_valid    (sample_valid),
        .cmd             (cmd),
        .status          (status),
        .mean_depth      (mean_depth),
        .valid_pixels    (valid_pixels),
        .no_valid_pixels (no_valid_pixels)
    );

endmodule

`default_nettype wire

>>> src/crdm_divider.sv
// Restoring divider, one quotient bit per cycle while step is high: frame sum over pixel count.
// Depends on crdm_pkg for the count width.
`default_nettype none

module crdm_divider #(
    parameter int SUM_W = 34
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        step,
    input  wire logic [SUM_W-1:0]            dividend,
    input  wire logic [crdm_pkg::CNT_W-1:0]  divisor,
    output logic      [SUM_W-1:0]            quotient,
    output logic      [crdm_pkg::CNT_W-1:0]  denom,
    output logic                             last
);

    localparam int CW    = crdm_pkg::CNT_W;
    localparam int ITR_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quot_reg, quot_next;
    logic [CW:0]      rem_reg, rem_next;
    logic [CW-1:0]    den_reg;
    logic [ITR_W-1:0] itr_reg, itr_next;
    logic [CW:0]      trial;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg[CW-1:0], quot_reg[SUM_W-1]};
        ge    = (trial >= {1'b0, den_reg});
        quot_next = quot_reg;
        rem_next  = rem_reg;
        itr_next  = itr_reg;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            itr_next  = ITR_W'(SUM_W);
        end
        else if (step)
        begin
            quot_next = {quot_reg[SUM_W-2:0], ge};
            rem_next  = ge ? (trial - {1'b0, den_reg}) : trial;
            itr_next  = itr_reg - ITR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itr_reg <= '0;
        end
        else
        begin
            itr_reg <= itr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign quotient = quot_reg;
    assign denom    = den_reg;
    assign last     = (itr_reg == ITR_W'(1));

endmodule

`default_nettype wire

>>> src/crdm_datapath.sv
// Datapath: config registers, raster position, disc test pipeline,
// accumulators and result divider. Depends on crdm_pkg and crdm_divider.
`default_nettype none

module crdm_datapath #(
    parameter int DEPTH_BITS    = 16,
    parameter int MAX_FRAME_DIM = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [crdm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [crdm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [DEPTH_BITS-1:0]            depth_sample,
    input  wire logic                             sample_valid,
    input  wire crdm_pkg::dp_cmd_t                cmd,
    output crdm_pkg::dp_status_t                  status,
    output logic [crdm_pkg::MEAN_W-1:0]           mean_depth,
    output logic [crdm_pkg::CNT_W-1:0]            valid_pixels,
    output logic                                  no_valid_pixels
);

    localparam int CDW   = crdm_pkg::CFG_DIM_W;
    localparam int RW    = crdm_pkg::RADIUS_W;
    localparam int CW    = crdm_pkg::CNT_W;
    localparam int POS_W = $clog2(MAX_FRAME_DIM);
    localparam int DIM_W = $clog2(MAX_FRAME_DIM + 1);
    localparam int CMP_W = (DIM_W > CDW) ? DIM_W : CDW;
    localparam int WIN_W = ((DIM_W > RW) ? DIM_W : RW) + 1;
    localparam int SUM_W = DEPTH_BITS + CW;

    logic [CDW-1:0]        width_reg, height_reg;
    logic [RW-1:0]         radius_reg;
    logic [POS_W-1:0]      col_reg, col_next, row_reg, row_next;

    logic [DIM_W-1:0]      w_clamp, h_clamp;
    logic [POS_W-1:0]      w_last, h_last, col_c, row_c, cx, cy;
    logic                  last_col, last_row;
    logic [WIN_W-1:0]      cx_w, cy_w, r_w, col_w, row_w, w_w, h_w;
    logic [WIN_W-1:0]      x_lo, x_hi, y_lo, y_hi, x_hi_raw, y_hi_raw, dx_w, dy_w;
    logic                  in_x, in_y;

    logic                  s1_valid_reg, s1_last_reg, s1_hit_reg;
    logic [RW-1:0]         s1_dx_reg, s1_dy_reg, s1_r_reg;
    logic [DEPTH_BITS-1:0] s1_depth_reg;

    logic                  s2_valid_reg, s2_last_reg, s2_hit_reg;
    logic [2*RW-1:0]       s2_dx2_reg, s2_dy2_reg, s2_r2_reg;
    logic [DEPTH_BITS-1:0] s2_depth_reg;

    logic                  add;
    logic [SUM_W-1:0]      sum_reg, sum_total;
    logic [CW-1:0]         cnt_reg, cnt_total;

    logic [SUM_W-1:0]      quotient;
    logic [CW-1:0]         denom;
    logic                  div_last;

    // dimension clamp to [1, MAX_FRAME_DIM]
    always_comb
    begin
        if (width_reg == '0)
            w_clamp = DIM_W'(1);
        else if (CMP_W'(width_reg) > CMP_W'(MAX_FRAME_DIM))
            w_clamp = DIM_W'(MAX_FRAME_DIM);
        else
            w_clamp = DIM_W'(width_reg);
        if (height_reg == '0)
            h_clamp = DIM_W'(1);
        else if (CMP_W'(height_reg) > CMP_W'(MAX_FRAME_DIM))
            h_clamp = DIM_W'(MAX_FRAME_DIM);
        else
            h_clamp = DIM_W'(height_reg);
    end

    assign w_last   = POS_W'(w_clamp - DIM_W'(1));
    assign h_last   = POS_W'(h_clamp - DIM_W'(1));
    assign col_c    = (col_reg > w_last) ? w_last : col_reg;
    assign row_c    = (row_reg > h_last) ? h_last : row_reg;
    assign cx       = POS_W'(w_clamp >> 1);
    assign cy       = POS_W'(h_clamp >> 1);
    assign last_col = (col_c == w_last);
    assign last_row = (row_c == h_last);

    // half-open window, clipped to the frame
    always_comb
    begin
        cx_w  = WIN_W'(cx);
        cy_w  = WIN_W'(cy);
        r_w   = WIN_W'(radius_reg);
        col_w = WIN_W'(col_c);
        row_w = WIN_W'(row_c);
        w_w   = WIN_W'(w_clamp);
        h_w   = WIN_W'(h_clamp);
        x_lo  = (cx_w >= r_w) ? (cx_w - r_w) : '0;
        y_lo  = (cy_w >= r_w) ? (cy_w - r_w) : '0;
        x_hi_raw = cx_w + r_w;
        y_hi_raw = cy_w + r_w;
        x_hi  = (x_hi_raw > w_w) ? w_w : x_hi_raw;
        y_hi  = (y_hi_raw > h_w) ? h_w : y_hi_raw;
        in_x  = (col_w >= x_lo) && (col_w < x_hi);
        in_y  = (row_w >= y_lo) && (row_w < y_hi);
        dx_w  = (col_w >= cx_w) ? (col_w - cx_w) : (cx_w - col_w);
        dy_w  = (row_w >= cy_w) ? (row_w - cy_w) : (cy_w - row_w);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.accept)
        begin
            if (last_col && last_row)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = row_c + POS_W'(1);
            end
            else
            begin
                col_next = col_c + POS_W'(1);
                row_next = row_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= crdm_pkg::WIDTH_RESET;
            height_reg   <= crdm_pkg::HEIGHT_RESET;
            radius_reg   <= crdm_pkg::RADIUS_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    crdm_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    crdm_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                    crdm_pkg::CFG_DISC_RADIUS:  radius_reg <= cfg_data[RW-1:0];
                    default:                    ;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= cmd.accept;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.div_start)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_total;
                cnt_reg <= cnt_total;
            end
        end
    end

    // stage 1: window test and offsets; stage 2: squares
    always_ff @(posedge clk)
    begin
        s1_last_reg  <= last_col && last_row;
        s1_hit_reg   <= sample_valid && in_x && in_y;
        s1_dx_reg    <= dx_w[RW-1:0];
        s1_dy_reg    <= dy_w[RW-1:0];
        s1_r_reg     <= radius_reg;
        s1_depth_reg <= depth_sample;
        s2_last_reg  <= s1_last_reg;
        s2_hit_reg   <= s1_hit_reg;
        s2_dx2_reg   <= s1_dx_reg * s1_dx_reg;
        s2_dy2_reg   <= s1_dy_reg * s1_dy_reg;
        s2_r2_reg    <= s1_r_reg * s1_r_reg;
        s2_depth_reg <= s1_depth_reg;
    end

    assign add = s2_valid_reg && s2_hit_reg &&
                 (({1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg}) <= {1'b0, s2_r2_reg});
    assign sum_total = sum_reg + (add ? SUM_W'(s2_depth_reg) : '0);
    assign cnt_total = cnt_reg + CW'(add);

    crdm_divider #(
        .SUM_W(SUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (sum_total),
        .divisor  (cnt_total),
        .quotient (quotient),
        .denom    (denom),
        .last     (div_last)
    );

    assign status.frame_end = cmd.accept && last_col && last_row;
    assign status.s2_last   = s2_valid_reg && s2_last_reg;
    assign status.div_last  = div_last;

    assign no_valid_pixels = (denom == '0);
    assign valid_pixels    = denom;
    assign mean_depth      = no_valid_pixels ? '0 : quotient[crdm_pkg::MEAN_W-1:0];

endmodule

`default_nettype wire

>>> src/crdm_ctrl.sv
// Controller: frame accumulation, pipeline drain, divide and result hold.
// Depends on crdm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module crdm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire crdm_pkg::dp_status_t  status,
    output crdm_pkg::dp_cmd_t          cmd
);

    crdm_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crdm_pkg::ST_ACCUM:
            begin
                if (status.frame_end)
                    state_next = crdm_pkg::ST_DRAIN;
            end
            crdm_pkg::ST_DRAIN:
            begin
                if (status.s2_last)
                    state_next = crdm_pkg::ST_DIVIDE;
            end
            crdm_pkg::ST_DIVIDE:
            begin
                if (status.div_last)
                    state_next = crdm_pkg::ST_RESULT;
            end
            crdm_pkg::ST_RESULT:
            begin
                if (!out_stall)
                    state_next = crdm_pkg::ST_ACCUM;
            end
            default:
            begin
                state_next = crdm_pkg::ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = (state_reg != crdm_pkg::ST_ACCUM);
        out_valid     = (state_reg == crdm_pkg::ST_RESULT);
        cmd.accept    = in_valid && (state_reg == crdm_pkg::ST_ACCUM);
        cmd.div_start = status.s2_last && (state_reg == crdm_pkg::ST_DRAIN);
        cmd.div_step  = (state_reg == crdm_pkg::ST_DIVIDE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crdm_pkg::ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_SAME(a_last_only_in_drain, clk, rst_n, status.s2_last, state_reg == crdm_pkg::ST_DRAIN, "frame end reached accumulator outside drain")
    `ASSERT_ALWAYS(a_no_accept_on_result, clk, rst_n, !(out_valid && cmd.accept), "request accepted while result pending")
    `ASSERT_NEXT(a_divide_ends_in_result, clk, rst_n, cmd.div_step && status.div_last, out_valid, "divide finished without result")

endmodule

`default_nettype wire

>>> dv/tb_circular_roi_depth_mean_top.sv
// Testbench for circular_roi_depth_mean_top: streams depth frames in raster order and
// checks each per-frame mean, count and empty flag against an in-bench predictor.
// Depends on crdm_pkg and circular_roi_depth_mean_top.
`timescale 1ns / 1ps

module tb_circular_roi_depth_mean_top;

    localparam int MAX_DIM       = 4096;
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_PIXELS = 900;
    localparam int LIMIT_PIXELS  = 200;

    localparam logic [crdm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [crdm_pkg::MEAN_W-1:0] mean;
        logic [crdm_pkg::CNT_W-1:0]  count;
        logic                        no_valid;
    } roi_result_t;

    logic                            clk             = 1'b0;
    logic                            rst_n           = 1'b0;
    logic                            cfg_write_en    = 1'b0;
    logic [crdm_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [crdm_pkg::CFG_DATA_W-1:0] cfg_data        = '0;
    logic                            in_valid        = 1'b0;
    logic                            in_stall;
    logic [15:0]                     depth_sample    = '0;
    logic                            sample_valid    = 1'b0;
    logic                            out_valid;
    logic                            out_stall       = 1'b0;
    logic [crdm_pkg::MEAN_W-1:0]     mean_depth;
    logic [crdm_pkg::CNT_W-1:0]      valid_pixels;
    logic                            no_valid_pixels;

    // predictor copy of registers and frame state
    logic [crdm_pkg::CFG_DIM_W-1:0]  roi_width  = crdm_pkg::WIDTH_RESET;
    logic [crdm_pkg::CFG_DIM_W-1:0]  roi_height = crdm_pkg::HEIGHT_RESET;
    logic [crdm_pkg::RADIUS_W-1:0]   roi_radius = crdm_pkg::RADIUS_RESET;
    int                              col_pos    = 0;
    int                              row_pos    = 0;
    longint unsigned                 depth_acc  = 0;
    int unsigned                     disc_count = 0;

    roi_result_t frame_means[$];

    bit sending        = 1'b0;
    int burst_left     = 8;
    int stall_mode     = 0;
    int stall_mode_left = 0;
    int mismatches     = 0;
    int frames_checked = 0;
    int pixels_sent    = 0;
    int cfg_writes     = 0;

    circular_roi_depth_mean_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .depth_sample    (depth_sample),
        .sample_valid    (sample_valid),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mean_depth      (mean_depth),
        .valid_pixels    (valid_pixels),
        .no_valid_pixels (no_valid_pixels)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_dim(input logic [crdm_pkg::CFG_DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic bit in_span(input int pos, input int centre, input int r, input int dim);
        int lo;
        int hi;
        lo = centre - r;
        hi = centre + r;
        if (lo < 0)
            lo = 0;
        if (hi > dim)
            hi = dim;
        return (pos >= lo) && (pos < hi);
    endfunction

    function automatic void roi_accept_pixel(input logic [15:0] depth, input logic valid);
        int w;
        int h;
        int r;
        int cx;
        int cy;
        int col;
        int row;
        roi_result_t res;
        w   = clamp_dim(roi_width);
        h   = clamp_dim(roi_height);
        r   = int'(roi_radius);
        cx  = w / 2;
        cy  = h / 2;
        col = (col_pos > w - 1) ? w - 1 : col_pos;
        row = (row_pos > h - 1) ? h - 1 : row_pos;
        if (valid && in_span(col, cx, r, w) && in_span(row, cy, r, h)
            && ((col - cx) * (col - cx) + (row - cy) * (row - cy) <= r * r))
        begin
            depth_acc  += depth;
            disc_count += 1;
        end
        if (col == w - 1 && row == h - 1)
        begin
            res.mean = '0;
            if (disc_count != 0)
                res.mean = crdm_pkg::MEAN_W'(depth_acc / disc_count);
            res.count    = crdm_pkg::CNT_W'(disc_count);
            res.no_valid = (disc_count == 0);
            frame_means.insert(frame_means.size(), res);
            col_pos    = 0;
            row_pos    = 0;
            depth_acc  = 0;
            disc_count = 0;
        end
        else if (col == w - 1)
        begin
            col_pos = 0;
            row_pos = row + 1;
        end
        else
        begin
            col_pos = col + 1;
            row_pos = row;
        end
    endfunction

    function automatic logic [15:0] pick_depth();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want_v,
                                   input longint unsigned got_v);
        $display("mismatch %s: expected %0d got %0d at %0t", what, want_v, got_v, $time);
        mismatches++;
    endtask

    task automatic send_pixel(input logic [15:0] depth, input logic valid);
        in_valid     <= 1'b1;
        depth_sample <= depth;
        sample_valid <= valid;
        sending = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        roi_accept_pixel(depth, valid);
        pixels_sent++;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            sending = 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(4, 20)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
            burst_left = $urandom_range(0, 63);
        end
        else
            burst_left--;
    endtask

    task automatic send_frame(input int valid_pct);
        int n;
        n = clamp_dim(roi_width) * clamp_dim(roi_height);
        repeat (n) send_pixel(pick_depth(), $urandom_range(0, 99) < valid_pct);
    endtask

    task automatic wait_drained();
        if (sending)
        begin
            in_valid <= 1'b0;
            sending = 1'b0;
            @(posedge clk);
        end
        while (frame_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [crdm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [crdm_pkg::CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        case (idx)
            crdm_pkg::CFG_FRAME_WIDTH:  roi_width  = data;
            crdm_pkg::CFG_FRAME_HEIGHT: roi_height = data;
            crdm_pkg::CFG_DISC_RADIUS:  roi_radius = data[crdm_pkg::RADIUS_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic finish_writes();
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [crdm_pkg::CFG_DATA_W-1:0] w,
                             input logic [crdm_pkg::CFG_DATA_W-1:0] h,
                             input logic [crdm_pkg::CFG_DATA_W-1:0] r);
        wait_drained();
        write_reg(crdm_pkg::CFG_FRAME_WIDTH, w);
        write_reg(crdm_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(crdm_pkg::CFG_DISC_RADIUS, r);
        finish_writes();
    endtask

    task automatic test_directed_frames();
        set_frame(13'd3, 13'd3, 13'd1);
        repeat (9) send_pixel(16'hFFFF, 1'b1);
        for (int i = 0; i < 9; i++)
            send_pixel((i == 4) ? 16'h0000 : 16'(i * 1000 + 1), i != 1);
        // radius zero: empty window
        set_frame(13'd2, 13'd2, 13'd0);
        repeat (4) send_pixel(16'hFFFF, 1'b1);
        // all samples marked invalid
        set_frame(13'd2, 13'd1, 13'd1);
        repeat (2) send_pixel(16'hFFFF, 1'b0);
    endtask

    task automatic test_unused_register();
        set_frame(13'd5, 13'd3, 13'd2);
        write_reg(CFG_UNUSED, 13'h1FFF);
        finish_writes();
        send_frame(100);
        send_frame(50);
    endtask

    task automatic test_mid_frame_resize();
        set_frame(13'd8, 13'd8, 13'd3);
        repeat (20) send_pixel(pick_depth(), 1'b1);
        wait_drained();
        // shrink below the current position: next pixel closes the frame
        write_reg(crdm_pkg::CFG_FRAME_WIDTH, 13'd2);
        write_reg(crdm_pkg::CFG_FRAME_HEIGHT, 13'd2);
        finish_writes();
        send_pixel(pick_depth(), 1'b1);
        send_frame(100);
    endtask

    task automatic test_dimension_limits();
        set_frame(13'd0, 13'd0, 13'd1);
        repeat (3) send_frame(70);
        // oversized width, frame closed early by shrinking it
        set_frame(13'h1FFF, 13'd1, 13'd255);
        repeat (LIMIT_PIXELS) send_pixel(pick_depth(), 1'b1);
        wait_drained();
        write_reg(crdm_pkg::CFG_FRAME_WIDTH, 13'd2);
        finish_writes();
        send_pixel(pick_depth(), 1'b1);
        // oversized height, same again down the rows
        set_frame(13'd1, 13'h1FFF, 13'd255);
        repeat (LIMIT_PIXELS) send_pixel(pick_depth(), 1'b1);
        wait_drained();
        write_reg(crdm_pkg::CFG_FRAME_HEIGHT, 13'd2);
        finish_writes();
        send_pixel(pick_depth(), 1'b1);
    endtask

    task automatic test_random_frames();
        int target;
        int w;
        int h;
        int r;
        int pct;
        target = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < target)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
            if (w * h > 240)
                h = 240 / w;
            case ($urandom_range(0, 5))
                0: r = 0;
                1: r = $urandom_range(128, 255);
                2: r = $urandom_range(6, 20);
                default: r = $urandom_range(1, 5);
            endcase
            case ($urandom_range(0, 2))
                0: pct = 30;
                1: pct = 85;
                default: pct = 100;
            endcase
            set_frame(13'(w), 13'(h), {5'($urandom_range(0, 31)), 8'(r)});
            repeat ($urandom_range(1, 3)) send_frame(pct);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 300);
        end
        else
            stall_mode_left--;
        out_stall <= (stall_mode != 0) && ($urandom_range(0, 3) < stall_mode);
    end

    always @(posedge clk)
    begin : result_check
        roi_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_means.size() == 0)
                report_mismatch("unexpected result, mean", 0, mean_depth);
            else
            begin
                want = frame_means.pop_front();
                if (mean_depth !== want.mean)
                    report_mismatch("mean_depth", want.mean, mean_depth);
                if (valid_pixels !== want.count)
                    report_mismatch("valid_pixels", want.count, valid_pixels);
                if (no_valid_pixels !== want.no_valid)
                    report_mismatch("no_valid_pixels", want.no_valid, no_valid_pixels);
                frames_checked++;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_unused_register();
        test_mid_frame_resize();
        test_dimension_limits();
        test_random_frames();
        wait_drained();
        $display("sent %0d pixels under %0d register writes; %0d frame results compared",
                 pixels_sent, cfg_writes, frames_checked);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d frame results outstanding", frame_means.size());
        $display("FAIL");
        $finish;
    end

endmodule
